/* rtl/http_chunked_body_decoder_defines.svh */
// Assertion helpers shared by the decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Checked only out of reset.
`define HCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define HCBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/hcbd_pkg.sv */
package hcbd_pkg;

  localparam int unsigned MAX_SIZE_DIGITS = 16;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned SIZE_W = 64;

  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_SP   = 8'd32;
  localparam logic [7:0] CH_TAB  = 8'd9;
  localparam logic [7:0] CH_SEMI = 8'd59;

  typedef enum logic [3:0] {
    PH_SIZE_LEAD   = 4'd0,
    PH_SIZE_DIGITS = 4'd1,
    PH_SIZE_TRAIL  = 4'd2,
    PH_SIZE_EXT    = 4'd3,
    PH_SIZE_LF     = 4'd4,
    PH_DATA        = 4'd5,
    PH_DATA_CR     = 4'd6,
    PH_DATA_LF     = 4'd7,
    PH_TR_START    = 4'd8,
    PH_TR_LINE     = 4'd9,
    PH_TR_LINE_LF  = 4'd10,
    PH_TR_END_LF   = 4'd11,
    PH_DONE        = 4'd12,
    PH_ERROR       = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ERROR    = 2'd2,
    ST_BEYOND   = 2'd3
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b inside {[8'd48:8'd57]}) begin
      h.val = 4'(b - 8'd48);
    end else if (b inside {[8'd97:8'd102]}) begin
      h.val = 4'(b - 8'd87);
    end else if (b inside {[8'd65:8'd70]}) begin
      h.val = 4'(b - 8'd55);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

endpackage

/* rtl/hcbd_if.sv */
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] data_byte;

  modport source (output valid, output restart, output data_byte, input ready);
  modport sink   (input valid, input restart, input data_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic [1:0] status;

  modport source (output valid, output payload_byte, output payload_valid, output status,
                  input ready);
  modport sink   (input valid, input payload_byte, input payload_valid, input status,
                  output ready);
endinterface

/* rtl/http_chunked_body_decoder.sv */
// Channel   Dir  Payload                                 Accepted when
// in_i      in   restart, data_byte                      valid & ready
// out_o     out  payload_byte, payload_valid, status     valid & ready
//
// One input byte gives one result item; a byte is taken every cycle unless
// the result register is full and out_o.ready is low. The parser state and
// the result register load on the same edge that accepts the byte.
// in_i.ready stays high while the result register is empty or being drained,
// so a full register stalls input only while out_o.ready is low.
// rst_ni clears the parser to size-line start and empties the result register.
`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  hcbd_in_if.sink         in_i,
  hcbd_out_if.source      out_o
);

  hcbd_pkg::phase_e                     phase_q, phase_d, ph;
  logic [hcbd_pkg::CNT_W-1:0]           digits_q, digits_d, dg;
  logic [hcbd_pkg::SIZE_W-1:0]          chunk_q, chunk_d, ck;

  logic                                 out_valid_q;
  logic [7:0]                           out_byte_q, out_byte_d;
  logic                                 out_pv_q, out_pv_d;
  hcbd_pkg::status_e                    out_st_q, out_st_d;

  logic                                 in_fire;
  logic [7:0]                           b;
  hcbd_pkg::hex_t                       hx;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign hx         = hcbd_pkg::hex_digit(b);

  always_comb begin
    hcbd_pkg::status_e st;
    logic              pv;
    // restart applies before this byte is parsed
    ph = in_i.restart ? hcbd_pkg::PH_SIZE_LEAD : phase_q;
    dg = in_i.restart ? '0 : digits_q;
    ck = in_i.restart ? '0 : chunk_q;

    phase_d  = ph;
    digits_d = dg;
    chunk_d  = ck;
    st       = hcbd_pkg::ST_PROGRESS;
    pv       = 1'b0;

    case (ph)
      hcbd_pkg::PH_SIZE_LEAD, hcbd_pkg::PH_SIZE_DIGITS, hcbd_pkg::PH_SIZE_TRAIL: begin
        if (hcbd_pkg::is_blank(b)) begin
          if (ph == hcbd_pkg::PH_SIZE_DIGITS) phase_d = hcbd_pkg::PH_SIZE_TRAIL;
        end else if (b == hcbd_pkg::CH_SEMI || b == hcbd_pkg::CH_CR) begin
          if (dg == '0) begin
            phase_d = hcbd_pkg::PH_ERROR;
          end else begin
            phase_d = (b == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_SIZE_LF : hcbd_pkg::PH_SIZE_EXT;
          end
        end else if (hx.ok && ph != hcbd_pkg::PH_SIZE_TRAIL) begin
          if (dg >= hcbd_pkg::CNT_W'(hcbd_pkg::MAX_SIZE_DIGITS)) begin
            phase_d = hcbd_pkg::PH_ERROR;
          end else begin
            chunk_d  = {ck[hcbd_pkg::SIZE_W-5:0], hx.val};
            digits_d = dg + hcbd_pkg::CNT_W'(1);
            phase_d  = hcbd_pkg::PH_SIZE_DIGITS;
          end
        end else begin
          phase_d = hcbd_pkg::PH_ERROR;
        end
      end
      hcbd_pkg::PH_SIZE_EXT: begin
        if (b == hcbd_pkg::CH_CR) phase_d = hcbd_pkg::PH_SIZE_LF;
      end
      hcbd_pkg::PH_SIZE_LF: begin
        if (b != hcbd_pkg::CH_LF) begin
          phase_d = hcbd_pkg::PH_ERROR;
        end else begin
          digits_d = '0;
          phase_d  = (ck == '0) ? hcbd_pkg::PH_TR_START : hcbd_pkg::PH_DATA;
        end
      end
      hcbd_pkg::PH_DATA: begin
        pv      = 1'b1;
        chunk_d = ck - hcbd_pkg::SIZE_W'(1);
        // last payload byte of the chunk
        if (ck == hcbd_pkg::SIZE_W'(1)) phase_d = hcbd_pkg::PH_DATA_CR;
      end
      hcbd_pkg::PH_DATA_CR: begin
        phase_d = (b == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_DATA_LF : hcbd_pkg::PH_ERROR;
      end
      hcbd_pkg::PH_DATA_LF: begin
        phase_d = (b == hcbd_pkg::CH_LF) ? hcbd_pkg::PH_SIZE_LEAD : hcbd_pkg::PH_ERROR;
      end
      hcbd_pkg::PH_TR_START: begin
        phase_d = (b == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_TR_END_LF : hcbd_pkg::PH_TR_LINE;
      end
      hcbd_pkg::PH_TR_LINE: begin
        if (b == hcbd_pkg::CH_CR) phase_d = hcbd_pkg::PH_TR_LINE_LF;
      end
      hcbd_pkg::PH_TR_LINE_LF: begin
        phase_d = (b == hcbd_pkg::CH_LF) ? hcbd_pkg::PH_TR_START : hcbd_pkg::PH_ERROR;
      end
      hcbd_pkg::PH_TR_END_LF: begin
        if (b == hcbd_pkg::CH_LF) begin
          phase_d = hcbd_pkg::PH_DONE;
          st      = hcbd_pkg::ST_COMPLETE;
        end else begin
          phase_d = hcbd_pkg::PH_ERROR;
        end
      end
      hcbd_pkg::PH_DONE: begin
        st = hcbd_pkg::ST_BEYOND;
      end
      default: begin
        phase_d = hcbd_pkg::PH_ERROR;
      end
    endcase

    if (phase_d == hcbd_pkg::PH_ERROR) begin
      st = hcbd_pkg::ST_ERROR;
      pv = 1'b0;
    end

    out_pv_d   = pv;
    out_st_d   = st;
    out_byte_d = pv ? b : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hcbd_pkg::PH_SIZE_LEAD;
      digits_q    <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q  <= phase_d;
        digits_q <= digits_d;
        chunk_q  <= chunk_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q <= out_byte_d;
      out_pv_q   <= out_pv_d;
      out_st_q   <= out_st_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_byte  = out_byte_q;
  assign out_o.payload_valid = out_pv_q;
  assign out_o.status        = out_st_q;

  `HCBD_ASSERT(a_pv_in_progress, out_o.valid && out_o.payload_valid |-> out_o.status == hcbd_pkg::ST_PROGRESS, "payload byte with non-progress status")
  `HCBD_ASSERT(a_byte_zero, out_o.valid && !out_o.payload_valid |-> out_o.payload_byte == 8'd0, "non-payload item carries a byte")
  `HCBD_ASSERT(a_error_sticky, in_fire && !in_i.restart && phase_q == hcbd_pkg::PH_ERROR |=> out_o.status == hcbd_pkg::ST_ERROR, "error phase left without restart")
  `HCBD_ASSERT_ALWAYS(a_data_nonzero, phase_q == hcbd_pkg::PH_DATA |-> chunk_q != '0, "payload phase with no bytes due")

endmodule
